// ===== rtl/core/bfe_pkg.sv =====
package bfe_pkg;

  localparam int unsigned CNT_W  = 11;
  localparam int unsigned OFS_W  = 10;
  localparam int unsigned TOT_W  = 32;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CMD_W  = 3;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(1024);

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 3'd0,
    CMD_READ  = 3'd1,
    CMD_PEEK  = 3'd2,
    CMD_POP   = 3'd3,
    CMD_END   = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] data_byte;
    logic [OFS_W-1:0]  offset;
    logic [CNT_W-1:0]  count;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              out_valid;
    logic              accepted;
    logic [CNT_W-1:0]  occupancy;
    logic [CNT_W-1:0]  free_space;
    logic              input_closed;
    logic              at_eof;
    logic [TOT_W-1:0]  total_written;
    logic [TOT_W-1:0]  total_read;
  } out_item_t;

  // Status of one beat, everything but the byte that comes out of the store.
  typedef struct packed {
    logic              hit;
    logic              accepted;
    logic [CNT_W-1:0]  occupancy;
    logic [CNT_W-1:0]  free_space;
    logic              input_closed;
    logic              at_eof;
    logic [TOT_W-1:0]  total_written;
    logic [TOT_W-1:0]  total_read;
  } stat_t;

endpackage

// ===== rtl/core/bfe_store.sv =====
module bfe_store #(
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read, so a waiting beat keeps its byte.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/bfe_ctrl.sv =====
module bfe_ctrl #(
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [10:0]       cfg_wdata_i,
  input  logic              in_fire_i,
  input  bfe_pkg::in_item_t in_data_i,
  output logic              mem_we_o,
  output logic [AW-1:0]     mem_waddr_o,
  output logic [7:0]        mem_wdata_o,
  output logic              mem_re_o,
  output logic [AW-1:0]     mem_raddr_o,
  output bfe_pkg::stat_t    stat_o
);

  import bfe_pkg::*;

  // Wide enough for pointer plus count and for DEPTH itself.
  localparam int unsigned SW = ((AW > CNT_W) ? AW : CNT_W) + 2;

  logic [CNT_W-1:0] cap_q;
  logic [AW-1:0]    head_q, head_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic             closed_q, closed_d;
  logic [TOT_W-1:0] wtot_q, wtot_d;
  logic [TOT_W-1:0] rtot_q, rtot_d;

  logic [CNT_W-1:0] eff_cap;
  logic [CNT_W-1:0] disc;
  logic             acc;
  logic             hit;
  logic             re;
  logic [AW-1:0]    raddr;

  function automatic logic [AW-1:0] wrap(input logic [SW-1:0] p);
    logic [SW-1:0] r;
    r = (p >= SW'(DEPTH)) ? p - SW'(DEPTH) : p;
    return r[AW-1:0];
  endfunction

  always_comb begin
    eff_cap = (SW'(cap_q) > SW'(DEPTH)) ? CNT_W'(DEPTH) : cap_q;
    disc    = '0;
    acc     = 1'b0;
    hit     = 1'b0;
    re      = 1'b0;
    raddr   = head_q;
    closed_d = closed_q;
    case (in_data_i.cmd)
      CMD_WRITE: begin
        if (!closed_q && (fill_q < eff_cap)) begin
          acc = 1'b1;
        end
      end
      CMD_READ: begin
        if (fill_q != '0) begin
          re   = 1'b1;
          hit  = 1'b1;
          disc = CNT_W'(1);
        end
      end
      CMD_PEEK: begin
        if (CNT_W'(in_data_i.offset) < fill_q) begin
          re    = 1'b1;
          hit   = 1'b1;
          raddr = wrap(SW'(head_q) + SW'(in_data_i.offset));
        end
      end
      CMD_POP: begin
        disc = (in_data_i.count > fill_q) ? fill_q : in_data_i.count;
      end
      CMD_END: begin
        closed_d = 1'b1;
      end
      default: begin
      end
    endcase
    head_d = wrap(SW'(head_q) + SW'(disc));
    fill_d = fill_q + CNT_W'(acc) - disc;
    wtot_d = wtot_q + TOT_W'(acc);
    rtot_d = rtot_q + TOT_W'(disc);
  end

  assign mem_we_o    = in_fire_i && acc;
  assign mem_waddr_o = wrap(SW'(head_q) + SW'(fill_q));
  assign mem_wdata_o = in_data_i.data_byte;
  assign mem_re_o    = in_fire_i && re;
  assign mem_raddr_o = raddr;

  always_comb begin
    stat_o.hit           = hit;
    stat_o.accepted      = acc;
    stat_o.occupancy     = fill_d;
    stat_o.free_space    = (eff_cap > fill_d) ? eff_cap - fill_d : '0;
    stat_o.input_closed  = closed_d;
    stat_o.at_eof        = closed_d && (fill_d == '0);
    stat_o.total_written = wtot_d;
    stat_o.total_read    = rtot_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      fill_q   <= '0;
      closed_q <= 1'b0;
      wtot_q   <= '0;
      rtot_q   <= '0;
    end else if (in_fire_i) begin
      head_q   <= head_d;
      fill_q   <= fill_d;
      closed_q <= closed_d;
      wtot_q   <= wtot_d;
      rtot_q   <= rtot_d;
    end
  end

endmodule

// ===== rtl/core/byte_fifo_with_eof.sv =====
// Byte FIFO with end-of-input mark. Each input beat carries one command (write,
// read, peek, pop count, end input) and yields exactly one result beat with the
// byte found and the status after the command. One beat is taken every cycle
// while in_stall_o is low; each result passes through the pointer update and
// the registered read of the byte store, then through the output register.
// The capacity register is clamped to DEPTH and should be written only while
// no beat is in flight. Store entries carry no reset.
module byte_fifo_with_eof #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [10:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bfe_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bfe_pkg::out_item_t out_data_o
);

  import bfe_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic          in_fire;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;
  stat_t         stat;

  logic          s1_valid_q, s1_valid_d;
  stat_t         s1_stat_q;
  logic          out_valid_q, out_valid_d;
  out_item_t     out_data_q, out_data_d;
  logic          out_free;
  logic          s1_move;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;

  bfe_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_fire_i   (in_fire),
    .in_data_i   (in_data_i),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .stat_o      (stat)
  );

  bfe_store #(.DEPTH(DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    s1_valid_d = in_fire || (s1_valid_q && !s1_move);
    out_valid_d = s1_move || (out_valid_q && out_stall_i);
    out_data_d.out_byte      = s1_stat_q.hit ? mem_rdata : '0;
    out_data_d.out_valid     = s1_stat_q.hit;
    out_data_d.accepted      = s1_stat_q.accepted;
    out_data_d.occupancy     = s1_stat_q.occupancy;
    out_data_d.free_space    = s1_stat_q.free_space;
    out_data_d.input_closed  = s1_stat_q.input_closed;
    out_data_d.at_eof        = s1_stat_q.at_eof;
    out_data_d.total_written = s1_stat_q.total_written;
    out_data_d.total_read    = s1_stat_q.total_read;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_stat_q <= stat;
    end
    if (s1_move) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(out_data_o.occupancy) <= DEPTH))
    else $error("occupancy beyond store depth");

  a_eof_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.at_eof) |->
      (out_data_o.input_closed && (out_data_o.occupancy == '0)))
    else $error("eof reported while bytes remain or input open");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.out_valid) |-> (out_data_o.out_byte == '0))
    else $error("byte driven without a hit");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_move) |-> !in_fire)
    else $error("beat accepted over a waiting beat");

endmodule
